// File: src/bpu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bpu_pkg;

   // colour lanes, in result order
   localparam int unsigned LANE_CNT = 4;
   localparam int unsigned LANE_RED = 0;
   localparam int unsigned LANE_GREEN = 1;
   localparam int unsigned LANE_BLUE = 2;
   localparam int unsigned LANE_ALPHA = 3;

   localparam int unsigned WORD_W = 32;
   localparam int unsigned COMP_W = 8;
   localparam int unsigned POS_W = 6;
   localparam int unsigned NUM_W = 15;
   localparam int unsigned RECIP_W = 24;
   localparam int unsigned RECIP_SHIFT = 23;

   typedef logic [WORD_W-1:0] word_type;
   typedef logic [COMP_W-1:0] comp_type;
   typedef logic [POS_W-1:0] pos_type;

   // register indexes of the control port
   typedef enum logic [2:0] {
      CSR_WIDE_PIXEL_MODE  = 3'd0,
      CSR_BITFIELDS_ENABLE = 3'd1,
      CSR_RED_MASK         = 3'd2,
      CSR_GREEN_MASK       = 3'd3,
      CSR_BLUE_MASK        = 3'd4,
      CSR_ALPHA_MASK       = 3'd5
   } csr_index_type;

   // register reset values
   localparam logic     RST_WIDE_PIXEL_MODE = 1'b1;
   localparam logic     RST_BITFIELDS_ENABLE = 1'b0;
   localparam word_type RST_RED_MASK = 32'h00FF_0000;
   localparam word_type RST_GREEN_MASK = 32'h0000_FF00;
   localparam word_type RST_BLUE_MASK = 32'h0000_00FF;
   localparam word_type RST_ALPHA_MASK = 32'h0000_0000;

   localparam comp_type OPAQUE_ALPHA = 8'hFF;

   // ceil(2^23 / (2^n - 1)) for short fields of n = 1..7 bits
   localparam logic [RECIP_W-1:0] RECIP_TBL [8] = '{
      24'd0, 24'd8388608, 24'd2796203, 24'd1198373,
      24'd559241, 24'd270601, 24'd133153, 24'd66053
   };

   // number of zero bits below the lowest one, word width for zero
   function automatic pos_type trail_zeros(input word_type value);
      pos_type cnt;
      cnt = pos_type'(WORD_W);
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (value[i]) begin
            cnt = pos_type'(i);
         end
      end
      return cnt;
   endfunction

endpackage

`default_nettype wire

// File: src/bpu_ifs.sv
`timescale 1ns / 1ps
`default_nettype none

// pixel request channel
interface bpu_req_if;
   logic               valid;
   logic               ready;
   bpu_pkg::word_type  pixel_word;

   modport source (output valid, output pixel_word, input ready);
   modport sink (input valid, input pixel_word, output ready);
endinterface

// colour result channel
interface bpu_rsp_if;
   logic               valid;
   logic               ready;
   bpu_pkg::comp_type  red;
   bpu_pkg::comp_type  green;
   bpu_pkg::comp_type  blue;
   bpu_pkg::comp_type  alpha;

   modport source (output valid, output red, output green, output blue, output alpha,
                   input ready);
   modport sink (input valid, input red, input green, input blue, input alpha,
                 output ready);
endinterface

// register write channel
interface bpu_csr_if;
   logic                    valid;
   logic                    ready;
   bpu_pkg::csr_index_type  index;
   bpu_pkg::word_type       data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: src/bmp_pixel_unpack_core.sv
`timescale 1ns / 1ps
`default_nettype none

// bmp_pixel_unpack_core: raw BMP pixel word to 8-bit red, green, blue, alpha
//
// req_if carries one 32-bit pixel per request; rsp_if returns the four
// components; csr_if writes the mode bits and the four channel masks, one
// register per write, and is always ready. The user must write registers only
// while no request is in flight; the block itself does not enforce it.
//
// Five register stages; a new request is taken every cycle unless a receiver
// stall holds the pipeline. The stages are the mask position search, the field
// shift, the run-length count, the 8-bit take or the short-field numerator, and
// a 15x24 reciprocal multiply for short fields.
//
// All stages advance together whenever the output register is empty or being
// taken, so a receiver stall holds every stage and drops req_if.ready.
// Reset empties the pipeline and loads the register defaults: 32-bit pixels,
// fixed byte order, masks for red, green and blue bytes, no alpha.

module bmp_pixel_unpack_core (
   input  wire logic  clock,
   input  wire logic  reset,
   bpu_req_if.sink    req_if,
   bpu_rsp_if.source  rsp_if,
   bpu_csr_if.sink    csr_if
);
   import bpu_pkg::*;

   // configuration registers
   logic     wide_ff;
   logic     bfen_ff;
   word_type mask_ff [LANE_CNT];

   // pipeline control
   logic     adv;
   logic     v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;

   // fixed byte order result and mode select, carried alongside
   word_type fix1_ff, fix2_ff, fix3_ff, fix4_ff, fix_in;
   logic     bf1_ff, bf2_ff, bf3_ff, bf4_ff, bf_in;

   // stage 1: word, masks and run positions
   word_type word1_ff;
   word_type mask1_ff [LANE_CNT];
   pos_type  pos1_ff [LANE_CNT];
   pos_type  pos_in [LANE_CNT];

   // stage 2: field shifted down
   word_type wsh2_ff [LANE_CNT];
   word_type msh2_ff [LANE_CNT];
   logic     zero2_ff [LANE_CNT];
   word_type wsh_in [LANE_CNT];
   word_type msh_in [LANE_CNT];

   // stage 3: isolated field and its width
   word_type x3_ff [LANE_CNT];
   pos_type  wid3_ff [LANE_CNT];
   logic     zero3_ff [LANE_CNT];
   word_type x_in [LANE_CNT];
   pos_type  wid_in [LANE_CNT];

   // stage 4: long-field byte or short-field numerator and reciprocal
   comp_type top4_ff [LANE_CNT];
   logic [NUM_W-1:0] num4_ff [LANE_CNT];
   logic [RECIP_W-1:0] rcp4_ff [LANE_CNT];
   logic     long4_ff [LANE_CNT];
   logic     zero4_ff [LANE_CNT];
   comp_type top_in [LANE_CNT];
   logic [NUM_W-1:0] num_in [LANE_CNT];
   logic [RECIP_W-1:0] rcp_in [LANE_CNT];
   logic     long_in [LANE_CNT];

   // stage 5: output register
   comp_type out5_ff [LANE_CNT];
   comp_type out_in [LANE_CNT];
   logic [NUM_W+RECIP_W-1:0] prod [LANE_CNT];

   assign adv = !v5_ff || rsp_if.ready;
   assign req_if.ready = adv;
   assign csr_if.ready = 1'b1;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         wide_ff <= RST_WIDE_PIXEL_MODE;
         bfen_ff <= RST_BITFIELDS_ENABLE;
         mask_ff[LANE_RED] <= RST_RED_MASK;
         mask_ff[LANE_GREEN] <= RST_GREEN_MASK;
         mask_ff[LANE_BLUE] <= RST_BLUE_MASK;
         mask_ff[LANE_ALPHA] <= RST_ALPHA_MASK;
      end else if (csr_if.valid) begin
         case (csr_if.index)
            CSR_WIDE_PIXEL_MODE: begin
               wide_ff <= csr_if.data[0];
            end
            CSR_BITFIELDS_ENABLE: begin
               bfen_ff <= csr_if.data[0];
            end
            CSR_RED_MASK: begin
               mask_ff[LANE_RED] <= csr_if.data;
            end
            CSR_GREEN_MASK: begin
               mask_ff[LANE_GREEN] <= csr_if.data;
            end
            CSR_BLUE_MASK: begin
               mask_ff[LANE_BLUE] <= csr_if.data;
            end
            CSR_ALPHA_MASK: begin
               mask_ff[LANE_ALPHA] <= csr_if.data;
            end
            default: begin
            end
         endcase
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_if.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   // fixed byte order regrouped into lane order, and mode at entry
   always_comb begin
      bf_in = wide_ff && bfen_ff;
      fix_in = {wide_ff ? req_if.pixel_word[31:24] : OPAQUE_ALPHA,
                req_if.pixel_word[7:0], req_if.pixel_word[15:8],
                req_if.pixel_word[23:16]};
   end

   // per-lane datapath logic
   always_comb begin
      for (int l = 0; l < LANE_CNT; l++) begin
         pos_in[l] = trail_zeros(mask_ff[l]);
         wsh_in[l] = word1_ff >> pos1_ff[l];
         msh_in[l] = mask1_ff[l] >> pos1_ff[l];
         // low run of ones: msh with everything from the first zero upward cleared
         x_in[l] = wsh2_ff[l] & msh2_ff[l] & ~(msh2_ff[l] + word_type'(1));
         wid_in[l] = trail_zeros(~msh2_ff[l]);
         long_in[l] = wid3_ff[l] >= pos_type'(COMP_W);
         top_in[l] = comp_type'(x3_ff[l] >> (wid3_ff[l] - pos_type'(COMP_W)));
         num_in[l] = {x3_ff[l][6:0], 8'd0} - {8'd0, x3_ff[l][6:0]};
         rcp_in[l] = RECIP_TBL[wid3_ff[l][2:0]];
         prod[l] = {{RECIP_W{1'b0}}, num4_ff[l]} * {{NUM_W{1'b0}}, rcp4_ff[l]};
         if (zero4_ff[l]) begin
            out_in[l] = '0;
         end else if (long4_ff[l]) begin
            out_in[l] = top4_ff[l];
         end else begin
            out_in[l] = prod[l][RECIP_SHIFT +: COMP_W];
         end
         if (!bf4_ff) begin
            out_in[l] = fix4_ff[l*COMP_W +: COMP_W];
         end
      end
   end

   // pipeline data registers
   always_ff @(posedge clock) begin
      if (adv) begin
         word1_ff <= req_if.pixel_word;
         fix1_ff <= fix_in;
         bf1_ff <= bf_in;
         fix2_ff <= fix1_ff;
         bf2_ff <= bf1_ff;
         fix3_ff <= fix2_ff;
         bf3_ff <= bf2_ff;
         fix4_ff <= fix3_ff;
         bf4_ff <= bf3_ff;
         for (int l = 0; l < LANE_CNT; l++) begin
            mask1_ff[l] <= mask_ff[l];
            pos1_ff[l] <= pos_in[l];
            wsh2_ff[l] <= wsh_in[l];
            msh2_ff[l] <= msh_in[l];
            zero2_ff[l] <= mask1_ff[l] == '0;
            x3_ff[l] <= x_in[l];
            wid3_ff[l] <= wid_in[l];
            zero3_ff[l] <= zero2_ff[l];
            top4_ff[l] <= top_in[l];
            num4_ff[l] <= num_in[l];
            rcp4_ff[l] <= rcp_in[l];
            long4_ff[l] <= long_in[l];
            zero4_ff[l] <= zero3_ff[l];
            out5_ff[l] <= out_in[l];
         end
      end
   end

   // result channel, one lane per component
   assign rsp_if.valid = v5_ff;
   assign rsp_if.red = out5_ff[LANE_RED];
   assign rsp_if.green = out5_ff[LANE_GREEN];
   assign rsp_if.blue = out5_ff[LANE_BLUE];
   assign rsp_if.alpha = out5_ff[LANE_ALPHA];

endmodule

`default_nettype wire
